FILE: src/assert_macros.svh
// assertion helpers used by gifd_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define GIFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gifd assertion failed");

// next-cycle implication, masked during reset
`define GIFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gifd assertion failed");

`endif

FILE: src/gifd_pkg.sv
// ----------------------------------------------------------------------------
// gifd_pkg
// shared types and codes of the gif lzw pixel decoder
// ----------------------------------------------------------------------------
package gifd_pkg;

  localparam int DICT_ENTRIES_DEF  = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;

  localparam logic [3:0] ROOT_RESET = 4'd8;

  // commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROOT       = 2'd0;
  localparam logic [1:0] REG_WIDTH      = 2'd1;
  localparam logic [1:0] REG_HEIGHT     = 2'd2;
  localparam logic [1:0] REG_INTERLACED = 2'd3;

  // interlace passes
  localparam logic [2:0] PASS_1 = 3'd1;
  localparam logic [2:0] PASS_2 = 3'd2;
  localparam logic [2:0] PASS_3 = 3'd3;
  localparam logic [2:0] PASS_4 = 3'd4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PIXEL   = 3'd1,
    ST_NEED    = 3'd2,
    ST_REFUSED = 3'd3,
    ST_END     = 3'd4,
    ST_ERROR   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_WALK,
    S_WALK_RD,
    S_POP,
    S_EMIT
  } dec_state_t;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [2:0]  pass;
  } raster_pos_t;

endpackage

FILE: src/gifd_in_if.sv
// ----------------------------------------------------------------------------
// gifd_in_if
// command channel: start, push byte, pull pixel
// ----------------------------------------------------------------------------
interface gifd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

FILE: src/gifd_out_if.sv
// ----------------------------------------------------------------------------
// gifd_out_if
// result channel: status and pixel word
// ----------------------------------------------------------------------------
interface gifd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  pixel_index;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic        last_pixel;

  modport source (output valid, output status, output pixel_index, output pixel_x,
                  output pixel_y, output last_pixel, input ready);
  modport sink (input valid, input status, input pixel_index, input pixel_x,
                input pixel_y, input last_pixel, output ready);
endinterface

FILE: src/gifd_cfg_if.sv
// ----------------------------------------------------------------------------
// gifd_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface gifd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

FILE: src/gifd_raster.sv
// ----------------------------------------------------------------------------
// gifd_raster
// raster position step, sequential or four-pass interlaced row order
// ----------------------------------------------------------------------------
module gifd_raster (
  input  gifd_pkg::raster_pos_t pos,
  input  logic [15:0]           image_width,
  input  logic [15:0]           image_height,
  input  logic                  interlaced,
  output gifd_pkg::raster_pos_t pos_nxt,
  output logic                  done
);
  import gifd_pkg::*;

  logic [16:0] w;
  logic [16:0] h;
  logic [16:0] col_inc;
  logic [16:0] y;
  logic [2:0]  p;
  logic        wrapped;

  assign w       = (image_width == 16'd0) ? 17'd1 : {1'b0, image_width};
  assign h       = (image_height == 16'd0) ? 17'd1 : {1'b0, image_height};
  assign col_inc = {1'b0, pos.col} + 17'd1;

  always_comb begin
    pos_nxt = pos;
    done    = 1'b0;
    y       = '0;
    p       = pos.pass;
    wrapped = 1'b0;
    if (col_inc < w) begin
      pos_nxt.col = col_inc[15:0];
    end else begin
      pos_nxt.col = '0;
      if (!interlaced) begin
        y           = {1'b0, pos.row} + 17'd1;
        pos_nxt.row = y[15:0];
        done        = (y >= h);
      end else begin
        if (p == PASS_1 || p == PASS_2) begin
          y = {1'b0, pos.row} + 17'd8;
        end else if (p == PASS_3) begin
          y = {1'b0, pos.row} + 17'd4;
        end else begin
          y = {1'b0, pos.row} + 17'd2;
        end
        // at most four pass changes
        for (int i = 0; i < 4; i++) begin
          if (!wrapped && y >= h) begin
            p = p + 3'd1;
            case (p)
              PASS_2:  y = 17'd4;
              PASS_3:  y = 17'd2;
              PASS_4:  y = 17'd1;
              default: wrapped = 1'b1;
            endcase
          end
        end
        pos_nxt.pass = p;
        if (wrapped) begin
          pos_nxt.row = '0;
          done        = 1'b1;
        end else begin
          pos_nxt.row = y[15:0];
        end
      end
    end
  end
endmodule

FILE: src/gif_lzw_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder_core: lzw raster decoder for one gif frame
// start and push pass from idle through the emit state into the output register;
// a pull that pops a stacked pixel passes top, pop and emit, a pull that decodes a
// fresh code adds a walk and a walk-read state per dictionary link, as the
// prefix/suffix memory read is registered, plus a top pass per clear code and byte taken
// synchronous active-low reset clears control state and loads config defaults
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder_core #(
  parameter int DICT_ENTRIES  = gifd_pkg::DICT_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = gifd_pkg::MAX_CODE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  gifd_in_if.sink     in_ch,
  gifd_out_if.source  out_ch,
  gifd_cfg_if.sink    cfg_ch
);
  import gifd_pkg::*;

  localparam int IDX_W     = $clog2(DICT_ENTRIES);
  localparam int NFC_W     = IDX_W + 1;
  localparam int CODE_W    = MAX_CODE_BITS;
  localparam int BUF_W     = CODE_W + 8;
  localparam int CNT_W     = $clog2(BUF_W);
  localparam int STK_DEPTH = DICT_ENTRIES + 1;
  localparam int STK_AW    = $clog2(STK_DEPTH);
  localparam int SD_W      = $clog2(STK_DEPTH + 1);

  // configuration registers
  logic [3:0]  root_cfg_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic        interlaced_r;

  // decoder state
  dec_state_t  state_r, state_nxt;
  logic [SD_W-1:0]   depth_r, depth_nxt;
  logic [3:0]        cw_r, cw_nxt;
  logic [NFC_W-1:0]  nfc_r, nfc_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic              pv_r, pv_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        sub_r, sub_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              held_v_r, held_v_nxt;
  raster_pos_t       pos_r, pos_nxt;
  logic              finished_r, finished_nxt;
  logic              failed_r, failed_nxt;

  // walk payload
  logic [CODE_W-1:0] cur_r, cur_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  // pending result
  status_t     res_status_r, res_status_nxt;
  logic [7:0]  res_index_r, res_index_nxt;
  logic [15:0] res_x_r, res_x_nxt;
  logic [15:0] res_y_r, res_y_nxt;
  logic        res_last_r, res_last_nxt;

  // output register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_index_r;
  logic [15:0] out_x_r;
  logic [15:0] out_y_r;
  logic        out_last_r;

  // memories
  logic [7:0]        stk_mem [STK_DEPTH];
  logic [CODE_W-1:0] pre_mem [DICT_ENTRIES];
  logic [7:0]        suf_mem [DICT_ENTRIES];
  logic [7:0]        stk_q;
  logic [CODE_W-1:0] pre_q;
  logic [7:0]        suf_q;
  logic              stk_we;
  logic [STK_AW-1:0] stk_wa, stk_ra;
  logic [7:0]        stk_wd;
  logic              dict_we;
  logic [IDX_W-1:0]  dict_wa, dict_ra;
  logic [CODE_W-1:0] pre_wd;
  logic [7:0]        suf_wd;

  // decode helpers
  logic              in_fire;
  logic              out_free;
  logic [3:0]        root_b;
  logic [15:0]       clr16;
  logic [15:0]       nfc16;
  logic [15:0]       cur16;
  logic [15:0]       code16;
  logic [15:0]       maxc16;
  logic [BUF_W-1:0]  code_mask;
  logic [CODE_W-1:0] code_w;
  logic [SD_W-1:0]   depth_m1;
  logic              need_bits;
  logic              is_end_code;
  logic              is_clr_code;
  logic              code_bad;
  logic              walk_more;
  logic              walk_bad_idx;
  logic              stack_full;
  logic              table_full;
  raster_pos_t       adv_pos;
  logic              adv_done;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.pixel_index = out_index_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.last_pixel  = out_last_r;

  // root size is clamped to one..eight and read live
  assign root_b = (root_cfg_r < 4'd1) ? 4'd1 : ((root_cfg_r > 4'd8) ? 4'd8 : root_cfg_r);
  assign clr16  = 16'd1 << root_b;
  assign nfc16  = 16'(nfc_r);
  assign cur16  = 16'(cur_r);
  assign maxc16 = (16'd1 << cw_r) - 16'd1;

  assign code_mask = (BUF_W'(1) << cw_r) - BUF_W'(1);
  assign code_w    = CODE_W'(buf_r & code_mask);
  assign code16    = 16'(code_w);
  assign depth_m1  = depth_r - SD_W'(1);

  assign need_bits    = 16'(cnt_r) < 16'(cw_r);
  assign is_end_code  = (code16 == clr16 + 16'd1);
  assign is_clr_code  = (code16 == clr16);
  // unknown code at start or after clear, or a code past the next free one
  assign code_bad     = (code16 >= nfc16) && (!pv_r || code16 > nfc16);
  assign walk_more    = cur16 > clr16;
  assign walk_bad_idx = cur16 >= 16'(DICT_ENTRIES);
  assign stack_full   = depth_r >= SD_W'(STK_DEPTH);
  // full table without a clear
  assign table_full   = pv_r && (nfc16 > maxc16 || nfc16 >= 16'(DICT_ENTRIES));

  gifd_raster u_raster (
    .pos          (pos_r),
    .image_width  (width_r),
    .image_height (height_r),
    .interlaced   (interlaced_r),
    .pos_nxt      (adv_pos),
    .done         (adv_done)
  );

  // expansion stack, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  // prefix/suffix dictionary
  always_ff @(posedge clk) begin
    if (dict_we) begin
      pre_mem[dict_wa] <= pre_wd;
      suf_mem[dict_wa] <= suf_wd;
    end
    pre_q <= pre_mem[dict_ra];
    suf_q <= suf_mem[dict_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.cmd == CMD_PULL) ? S_TOP : S_EMIT;
        end
      end
      S_TOP: begin
        if (failed_r || finished_r) begin
          state_nxt = S_EMIT;
        end else if (depth_r != '0) begin
          state_nxt = S_POP;
        end else if (need_bits) begin
          if (!held_v_r || (sub_r == 8'd0 && held_r == 8'd0)) begin
            state_nxt = S_EMIT;
          end
        end else if (is_end_code || (!is_clr_code && code_bad)) begin
          state_nxt = S_EMIT;
        end else if (!is_clr_code) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_more) begin
          state_nxt = walk_bad_idx ? S_EMIT : S_WALK_RD;
        end else begin
          state_nxt = (stack_full || table_full) ? S_EMIT : S_TOP;
        end
      end
      S_WALK_RD: state_nxt = stack_full ? S_EMIT : S_WALK;
      S_POP:     state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    depth_nxt    = depth_r;
    cw_nxt       = cw_r;
    nfc_nxt      = nfc_r;
    prev_nxt     = prev_r;
    pv_nxt       = pv_r;
    first_nxt    = first_r;
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    sub_nxt      = sub_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    pos_nxt      = pos_r;
    finished_nxt = finished_r;
    failed_nxt   = failed_r;
    cur_nxt      = cur_r;
    code_nxt     = code_r;

    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_last_nxt   = res_last_r;

    stk_we  = 1'b0;
    stk_wa  = depth_r[STK_AW-1:0];
    stk_wd  = cur_r[7:0];
    stk_ra  = depth_m1[STK_AW-1:0];
    dict_we = 1'b0;
    dict_wa = nfc_r[IDX_W-1:0];
    dict_ra = IDX_W'(cur_r);
    pre_wd  = prev_r;
    suf_wd  = cur_r[7:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ST_OK;
          res_index_nxt  = '0;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
          res_last_nxt   = 1'b0;
          case (in_ch.cmd)
            CMD_START: begin
              depth_nxt    = '0;
              cw_nxt       = root_b + 4'd1;
              nfc_nxt      = NFC_W'(clr16 + 16'd2);
              prev_nxt     = '0;
              pv_nxt       = 1'b0;
              first_nxt    = '0;
              buf_nxt      = '0;
              cnt_nxt      = '0;
              sub_nxt      = '0;
              held_nxt     = '0;
              held_v_nxt   = 1'b0;
              pos_nxt      = '{col: 16'd0, row: 16'd0, pass: PASS_1};
              finished_nxt = 1'b0;
              failed_nxt   = (root_cfg_r == 4'd0);
            end
            CMD_PUSH: begin
              if (held_v_r) begin
                res_status_nxt = ST_REFUSED;
              end else begin
                held_nxt   = in_ch.data_byte;
                held_v_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_TOP: begin
        if (failed_r) begin
          res_status_nxt = ST_ERROR;
        end else if (finished_r) begin
          res_status_nxt = ST_END;
        end else if (depth_r != '0) begin
          // pop; the read address is the new top
          depth_nxt = depth_m1;
        end else if (need_bits) begin
          if (!held_v_r) begin
            res_status_nxt = ST_NEED;
          end else begin
            held_v_nxt = 1'b0;
            if (sub_r == 8'd0) begin
              if (held_r == 8'd0) begin
                // zero-length sub-block ends the image
                finished_nxt   = 1'b1;
                res_status_nxt = ST_END;
              end else begin
                sub_nxt = held_r;
              end
            end else begin
              buf_nxt = buf_r | (BUF_W'(held_r) << cnt_r);
              cnt_nxt = cnt_r + CNT_W'(8);
              sub_nxt = sub_r - 8'd1;
            end
          end
        end else begin
          buf_nxt = buf_r >> cw_r;
          cnt_nxt = cnt_r - CNT_W'(cw_r);
          if (is_end_code) begin
            finished_nxt   = 1'b1;
            res_status_nxt = ST_END;
          end else if (is_clr_code) begin
            cw_nxt  = root_b + 4'd1;
            nfc_nxt = NFC_W'(clr16 + 16'd2);
            pv_nxt  = 1'b0;
          end else if (code_bad) begin
            failed_nxt     = 1'b1;
            depth_nxt      = '0;
            res_status_nxt = ST_ERROR;
          end else begin
            code_nxt = code_w;
            if (code16 == nfc16) begin
              // kwkwk: previous string plus its own first character
              stk_we    = 1'b1;
              stk_wa    = '0;
              stk_wd    = first_r;
              depth_nxt = SD_W'(1);
              cur_nxt   = prev_r;
            end else begin
              depth_nxt = '0;
              cur_nxt   = code_w;
            end
          end
        end
      end

      S_WALK: begin
        if (walk_more) begin
          if (walk_bad_idx) begin
            failed_nxt     = 1'b1;
            depth_nxt      = '0;
            res_status_nxt = ST_ERROR;
          end
        end else if (stack_full || table_full) begin
          failed_nxt     = 1'b1;
          depth_nxt      = '0;
          res_status_nxt = ST_ERROR;
        end else begin
          // root character closes the string, then the new entry is added
          stk_we    = 1'b1;
          depth_nxt = depth_r + SD_W'(1);
          first_nxt = cur_r[7:0];
          if (pv_r) begin
            dict_we = 1'b1;
            nfc_nxt = nfc_r + NFC_W'(1);
            if ((nfc16 + 16'd1) > maxc16 && cw_r < 4'(MAX_CODE_BITS)) begin
              cw_nxt = cw_r + 4'd1;
            end
          end
          prev_nxt = code_r;
          pv_nxt   = 1'b1;
        end
      end

      S_WALK_RD: begin
        if (stack_full) begin
          failed_nxt     = 1'b1;
          depth_nxt      = '0;
          res_status_nxt = ST_ERROR;
        end else begin
          stk_we    = 1'b1;
          stk_wd    = suf_q;
          depth_nxt = depth_r + SD_W'(1);
          cur_nxt   = pre_q;
        end
      end

      S_POP: begin
        res_status_nxt = ST_PIXEL;
        res_index_nxt  = stk_q;
        res_x_nxt      = pos_r.col;
        res_y_nxt      = pos_r.row;
        res_last_nxt   = adv_done;
        pos_nxt        = adv_pos;
        if (adv_done) begin
          finished_nxt = 1'b1;
          depth_nxt    = '0;
        end
      end

      default: ;
    endcase

    // non-pixel words carry zero fields
    if (state_r == S_TOP) begin
      res_index_nxt = '0;
      res_x_nxt     = '0;
      res_y_nxt     = '0;
      res_last_nxt  = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_cfg_r   <= ROOT_RESET;
      width_r      <= 16'd1;
      height_r     <= 16'd1;
      interlaced_r <= 1'b0;
      state_r      <= S_IDLE;
      depth_r      <= '0;
      cw_r         <= ROOT_RESET + 4'd1;
      nfc_r        <= NFC_W'((16'd1 << ROOT_RESET) + 16'd2);
      prev_r       <= '0;
      pv_r         <= 1'b0;
      first_r      <= '0;
      buf_r        <= '0;
      cnt_r        <= '0;
      sub_r        <= '0;
      held_r       <= '0;
      held_v_r     <= 1'b0;
      pos_r        <= '{col: 16'd0, row: 16'd0, pass: PASS_1};
      finished_r   <= 1'b0;
      failed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_ROOT:       root_cfg_r   <= cfg_ch.data[3:0];
          REG_WIDTH:      width_r      <= cfg_ch.data;
          REG_HEIGHT:     height_r     <= cfg_ch.data;
          REG_INTERLACED: interlaced_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      state_r    <= state_nxt;
      depth_r    <= depth_nxt;
      cw_r       <= cw_nxt;
      nfc_r      <= nfc_nxt;
      prev_r     <= prev_nxt;
      pv_r       <= pv_nxt;
      first_r    <= first_nxt;
      buf_r      <= buf_nxt;
      cnt_r      <= cnt_nxt;
      sub_r      <= sub_nxt;
      held_r     <= held_nxt;
      held_v_r   <= held_v_nxt;
      pos_r      <= pos_nxt;
      finished_r <= finished_nxt;
      failed_r   <= failed_nxt;
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    code_r       <= code_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_last_r   <= res_last_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_last_r   <= res_last_r;
    end
  end

endmodule

FILE: src/gifd_checker.sv
// ----------------------------------------------------------------------------
// gifd_checker
// port-level checks of the decoder result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gifd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [7:0]  out_index,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic        out_last
);
  import gifd_pkg::*;

  // stalled word holds
  `GIFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_status, out_index, out_x, out_y, out_last}))
  // only defined status codes
  `GIFD_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_status <= ST_ERROR)
  // words without a pixel carry zero fields
  `GIFD_ASSERT_IMPL(a_zero_fields, clk, rst_n, out_valid && out_status != ST_PIXEL, out_index == 8'd0 && out_x == 16'd0 && out_y == 16'd0 && !out_last)
  // raster completion only on a pixel
  `GIFD_ASSERT_IMPL(a_last_pixel, clk, rst_n, out_valid && out_last, out_status == ST_PIXEL)

endmodule

bind gif_lzw_pixel_decoder_core gifd_checker u_gifd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_index  (out_ch.pixel_index),
  .out_x      (out_ch.pixel_x),
  .out_y      (out_ch.pixel_y),
  .out_last   (out_ch.last_pixel)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: gif lzw pixel decoder testbench
// drives start, push, pull and unused command words, the push bytes taken from generated lzw streams, predicts
// every result word in a scoreboard and compares the words field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import gifd_pkg::*;

typedef struct {
  status_t    st;
  logic [7:0] idx;
  logic [15:0] x;
  logic [15:0] y;
  logic       last;
} pix_word_t;

class pixel_scoreboard;
  logic [3:0]  root_reg;
  logic [15:0] wid_reg;
  logic [15:0] hgt_reg;
  logic        lace_reg;

  logic [11:0] prefix_mem[4096];
  logic [7:0]  suffix_mem[4096];
  logic [7:0]  stk[4097];

  int unsigned depth, cw, nfree, prevc, prev_ok, firstc, bbuf, bcnt;
  int unsigned sub_left, held, held_ok, col, row, pass_no, done, bad;

  pix_word_t expected_q[$];
  int errors;

  function new();
    root_reg = ROOT_RESET;
    wid_reg  = 16'd1;
    hgt_reg  = 16'd1;
    lace_reg = 1'b0;
    foreach (prefix_mem[i]) prefix_mem[i] = '0;
    foreach (suffix_mem[i]) suffix_mem[i] = '0;
    foreach (stk[i]) stk[i] = '0;
    errors = 0;
    start_frame();
  endfunction

  function int unsigned rbits();
    if (root_reg < 1) return 1;
    if (root_reg > 8) return 8;
    return root_reg;
  endfunction

  function void start_frame();
    int unsigned r;
    r = rbits();
    depth = 0; cw = r + 1; nfree = (1 << r) + 2;
    prevc = 0; prev_ok = 0; firstc = 0;
    bbuf = 0; bcnt = 0; sub_left = 0; held = 0; held_ok = 0;
    col = 0; row = 0; pass_no = PASS_1; done = 0;
    bad = (root_reg == 0) ? 1 : 0;
  endfunction

  function void set_reg(logic [1:0] a, logic [15:0] v);
    case (a)
      REG_ROOT:       root_reg = v[3:0];
      REG_WIDTH:      wid_reg  = v;
      REG_HEIGHT:     hgt_reg  = v;
      REG_INTERLACED: lace_reg = v[0];
      default: ;
    endcase
  endfunction

  // returns 1 when the raster is complete
  function bit advance();
    int unsigned w, h, y;
    w = (wid_reg != 0) ? wid_reg : 1;
    h = (hgt_reg != 0) ? hgt_reg : 1;
    y = row;
    col++;
    if (col < w) return 0;
    col = 0;
    if (!lace_reg) begin
      y++;
      row = y & 16'hFFFF;
      return y >= h;
    end
    if (pass_no <= PASS_2) y += 8;
    else if (pass_no == PASS_3) y += 4;
    else y += 2;
    while (y >= h) begin
      pass_no++;
      if (pass_no == PASS_2) y = 4;
      else if (pass_no == PASS_3) y = 2;
      else if (pass_no == PASS_4) y = 1;
      else begin
        row = 0;
        return 1;
      end
    end
    row = y;
    return 0;
  endfunction

  function bit push_stk(int unsigned v);
    if (depth >= 4097) return 0;
    stk[depth] = v[7:0];
    depth++;
    return 1;
  endfunction

  function bit expand(int unsigned code, int unsigned clr);
    int unsigned cur, maxc;
    depth = 0;
    if (code >= nfree) begin
      if (!prev_ok || code > nfree) return 0;
      if (!push_stk(firstc)) return 0;
      cur = prevc;
    end else begin
      cur = code;
    end
    while (cur > clr) begin
      if (cur >= 4096) return 0;
      if (!push_stk(suffix_mem[cur])) return 0;
      cur = prefix_mem[cur];
    end
    if (!push_stk(cur)) return 0;
    firstc = cur & 8'hFF;
    if (prev_ok) begin
      maxc = (1 << cw) - 1;
      if (nfree > maxc || nfree >= 4096) return 0;
      prefix_mem[nfree] = prevc[11:0];
      suffix_mem[nfree] = cur[7:0];
      nfree++;
      if (nfree > maxc && cw < 12) cw++;
    end
    prevc = code & 12'hFFF;
    prev_ok = 1;
    return 1;
  endfunction

  function pix_word_t pull();
    pix_word_t w;
    int unsigned r, clr, code;
    w = '{ST_OK, 8'd0, 16'd0, 16'd0, 1'b0};
    while (1) begin
      if (bad) begin w.st = ST_ERROR; return w; end
      if (done) begin w.st = ST_END; return w; end
      if (depth > 0) begin
        depth--;
        w.st  = ST_PIXEL;
        w.idx = stk[depth];
        w.x   = col[15:0];
        w.y   = row[15:0];
        if (advance()) begin
          done = 1; depth = 0; w.last = 1'b1;
        end
        return w;
      end
      while (bcnt < cw) begin
        if (!held_ok) begin w.st = ST_NEED; return w; end
        held_ok = 0;
        if (sub_left == 0) begin
          if (held == 0) begin done = 1; w.st = ST_END; return w; end
          sub_left = held;
        end else begin
          bbuf |= held << bcnt;
          bcnt += 8;
          sub_left--;
        end
      end
      code = bbuf & ((1 << cw) - 1);
      bbuf >>= cw;
      bcnt -= cw;
      r = rbits();
      clr = 1 << r;
      if (code == clr + 1) begin done = 1; w.st = ST_END; return w; end
      if (code == clr) begin
        cw = r + 1; nfree = clr + 2; prev_ok = 0;
        continue;
      end
      if (!expand(code, clr)) begin
        bad = 1; depth = 0; w.st = ST_ERROR; return w;
      end
    end
  endfunction

  // accepted input word: predict its result word
  function status_t note_input(logic [1:0] c, logic [7:0] b);
    pix_word_t w;
    w = '{ST_OK, 8'd0, 16'd0, 16'd0, 1'b0};
    case (c)
      CMD_START: start_frame();
      CMD_PUSH: begin
        if (held_ok) w.st = ST_REFUSED;
        else begin held = b; held_ok = 1; end
      end
      CMD_PULL: w = pull();
      default: ;
    endcase
    expected_q.push_back(w);
    return w.st;
  endfunction

  function void check(logic [2:0] st, logic [7:0] idx, logic [15:0] x, logic [15:0] y,
                      logic last);
    pix_word_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual status %0d", $time, st);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (st !== e.st) begin
      $display("%0t: status expected %0d actual %0d", $time, e.st, st);
      errors++;
    end
    if (idx !== e.idx) begin
      $display("%0t: pixel_index expected %0d actual %0d", $time, e.idx, idx);
      errors++;
    end
    if (x !== e.x) begin
      $display("%0t: pixel_x expected %0d actual %0d", $time, e.x, x);
      errors++;
    end
    if (y !== e.y) begin
      $display("%0t: pixel_y expected %0d actual %0d", $time, e.y, y);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: last_pixel expected %0d actual %0d", $time, e.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 4000000;

  // stream flavors
  localparam int MODE_PLAIN       = 0;
  localparam int MODE_AFTER_CLEAR = 1; // unknown code right after clear
  localparam int MODE_BEYOND      = 2; // code past the next free code
  localparam int MODE_NO_END      = 3; // zero-length sub-block ends the image
  localparam int MODE_GARBLED     = 4; // one corrupted byte
  localparam int MODE_FULL        = 5; // grow to 12 bits, then overrun the table

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gifd_in_if  in_if();
  gifd_out_if out_if();
  gifd_cfg_if cfg_if();

  gif_lzw_pixel_decoder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pixel_scoreboard sb = new();

  logic [7:0] stream_q[$];
  int sent = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_cnt = 0;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = CMD_START;
    in_if.data_byte = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = REG_ROOT;
    cfg_if.data = 16'd0;
    out_if.ready = 1'b0;
  end

  // idle phases rotate with the word count: sender light / receiver heavy,
  // then the reverse, then no idling at all
  function automatic int phase();
    return (sent / 700) % 3;
  endfunction

  function automatic int tx_idle_pct();
    case (phase())
      0: return 17;
      1: return 73;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (phase())
      0: return 73;
      1: return 17;
      default: return 0;
    endcase
  endfunction

  // receiver: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_cnt = 400;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
    end
  end

  // result words are checked at the accepting edge
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check(out_if.status, out_if.pixel_index, out_if.pixel_x, out_if.pixel_y,
               out_if.last_pixel);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one command word, returns the predicted status
  task automatic send(input logic [1:0] c, input logic [7:0] b, output status_t st);
    if ($urandom_range(0, 99) < tx_idle_pct()) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= c;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    st = sb.note_input(c, b);
    sent++;
  endtask

  // drop valid and wait for every expected word plus the pipeline tail
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] a, input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= a;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(a, v);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input logic [3:0] root, input logic [15:0] w, input logic [15:0] h,
                       input logic lace);
    write_reg(REG_ROOT, {12'd0, root});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_INTERLACED, {15'd0, lace});
  endtask

  // lzw code stream generator, tracks code width like the decoder does
  task automatic build_stream(input int unsigned r, input int ncodes, input int mode);
    int unsigned clr, gnext, gw, code;
    bit gprev;
    bit [63:0] acc;
    int nb, i, len, k;
    logic [7:0] raw[$];

    clr = 1 << r; gnext = clr + 2; gw = r + 1; gprev = 0;
    acc = '0; nb = 0;
    stream_q.delete();

    for (i = -1; i < ncodes; i++) begin
      // leading clear on most streams
      if (i == -1) begin
        if ($urandom_range(0, 9) < 7) code = clr;
        else continue;
      end else if (gprev && gnext >= 4096) begin
        code = (mode == MODE_FULL) ? 0 : clr;
      end else if (i == ncodes / 2 && mode == MODE_AFTER_CLEAR) begin
        acc |= 64'(clr) << nb; nb += gw;
        gw = r + 1; gnext = clr + 2; gprev = 0;
        code = gnext;
      end else if (i == ncodes / 2 && mode == MODE_BEYOND) begin
        code = (gnext + 1 + $urandom_range(0, 3)) & ((1 << gw) - 1);
      end else if (mode != MODE_FULL && $urandom_range(0, 59) == 0) begin
        code = clr;
      end else if (!gprev || mode == MODE_FULL) begin
        code = $urandom_range(0, clr - 1);
      end else begin
        k = $urandom_range(0, 9);
        if (k < 5 || gnext <= clr + 2) code = $urandom_range(0, clr - 1);
        else if (k < 9) code = $urandom_range(clr + 2, gnext - 1);
        else code = gnext; // the KwKwK case
      end

      acc |= 64'(code) << nb;
      nb += gw;
      while (nb >= 8) begin
        raw.push_back(acc[7:0]);
        acc >>= 8;
        nb -= 8;
      end

      if (code == clr) begin
        gw = r + 1; gnext = clr + 2; gprev = 0;
      end else begin
        if (gprev) begin
          gnext++;
          if (gnext > (1 << gw) - 1 && gw < 12) gw++;
        end
        gprev = 1;
      end
      if (mode == MODE_FULL && gnext >= 4096 && code == 0 && i > 8) break;
    end

    if (mode != MODE_NO_END) begin
      acc |= 64'(clr + 1) << nb;
      nb += gw;
    end
    while (nb > 0) begin
      raw.push_back(acc[7:0]);
      acc >>= 8;
      nb -= 8;
    end
    if (mode == MODE_GARBLED && raw.size() > 0)
      raw[$urandom_range(0, raw.size() - 1)] = $urandom_range(0, 255);

    // split into sub-blocks, mostly short, sometimes full length
    while (raw.size() > 0) begin
      if ($urandom_range(0, 9) == 0) len = (raw.size() < 255) ? raw.size() : 255;
      else len = $urandom_range(1, (raw.size() < 8) ? raw.size() : 8);
      stream_q.push_back(len[7:0]);
      repeat (len) stream_q.push_back(raw.pop_front());
    end
    stream_q.push_back(8'd0);
  endtask

  // start, then pull pixels and feed bytes on demand, with some noise words
  task automatic run_frame();
    status_t st;
    int idx, k, guard;
    idx = 0;
    guard = 0;
    send(CMD_START, $urandom_range(0, 255), st);
    while (guard < 40000) begin
      guard++;
      k = $urandom_range(0, 99);
      if (k < 3) send(CMD_PUSH, $urandom_range(0, 255), st);
      else if (k == 3) send(2'd3, $urandom_range(0, 255), st);
      send(CMD_PULL, $urandom_range(0, 255), st);
      if (st == ST_NEED) begin
        if (idx >= stream_q.size()) break;
        send(CMD_PUSH, stream_q[idx], st);
        idx++;
        // a second push onto a full holder gets refused
        if ($urandom_range(0, 19) == 0) send(CMD_PUSH, $urandom_range(0, 255), st);
      end else if (st == ST_END || st == ST_ERROR) begin
        send(CMD_PULL, $urandom_range(0, 255), st);
        break;
      end
    end
    drain();
  endtask

  function automatic int pick_mode();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return MODE_AFTER_CLEAR;
    if (k == 1) return MODE_BEYOND;
    if (k == 2 || k == 3) return MODE_NO_END;
    if (k == 4) return MODE_GARBLED;
    return MODE_PLAIN;
  endfunction

  initial begin
    status_t st;
    int frames, start_sent;
    logic [3:0] root;
    logic [15:0] w, h;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: root zero gives an error from start on
    setup(4'd0, 16'd0, 16'd0, 1'b0);
    send(CMD_START, 8'h00, st);
    send(CMD_PULL, 8'hFF, st);
    send(CMD_PUSH, 8'hFF, st);
    send(2'd3, 8'hAA, st);
    drain();

    // root above eight acts as eight; zero-length sub-block ends the image
    setup(4'd15, 16'd65535, 16'd65535, 1'b1);
    send(CMD_START, 8'h55, st);
    send(CMD_PULL, 8'h00, st);
    send(CMD_PUSH, 8'h00, st);
    send(CMD_PUSH, 8'hFF, st);
    send(CMD_PULL, 8'h00, st);
    send(CMD_PULL, 8'h00, st);
    // two-byte sub-block with code zero
    send(CMD_START, 8'h00, st);
    send(CMD_PUSH, 8'h02, st);
    send(CMD_PULL, 8'h00, st);
    send(CMD_PUSH, 8'h00, st);
    send(CMD_PULL, 8'h00, st);
    send(CMD_PUSH, 8'hFE, st);
    send(CMD_PULL, 8'h00, st);
    send(CMD_PULL, 8'h00, st);
    drain();

    // extremes of the image size, interlace on and off
    setup(4'd1, 16'd1, 16'd1, 1'b0);
    build_stream(1, 20, MODE_PLAIN);
    run_frame();
    setup(4'd8, 16'd3, 16'd65535, 1'b1);
    build_stream(8, 40, MODE_PLAIN);
    run_frame();
    setup(4'd4, 16'd5, 16'd11, 1'b1);
    build_stream(4, 80, MODE_PLAIN);
    run_frame();

    // growth to 12 bits, then a code with the table full
    setup(4'd2, 16'd65535, 16'd65535, 1'b0);
    build_stream(2, 5000, MODE_FULL);
    run_frame();

    // random frames
    frames = 0;
    start_sent = sent;
    while (sent - start_sent < 2000) begin
      case ($urandom_range(0, 19))
        0: root = 4'd0;
        1: root = $urandom_range(9, 15);
        default: root = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: w = 16'd0;
        1: w = 16'd65535;
        default: w = $urandom_range(1, 24);
      endcase
      h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
      setup(root, w, h, $urandom_range(0, 1));
      // long receiver hold-off while the sender keeps offering words
      if (frames == 3) hold_req++;
      build_stream((root < 1) ? 1 : (root > 8) ? 8 : root, $urandom_range(5, 60),
                   pick_mode());
      run_frame();
      frames++;
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+src
src/gifd_pkg.sv
src/gifd_in_if.sv
src/gifd_out_if.sv
src/gifd_cfg_if.sv
src/gifd_raster.sv
src/gif_lzw_pixel_decoder_core.sv
src/gifd_checker.sv
dv/tb_top.sv
